// ===== src/cjt_pkg.sv =====
package cjt_pkg;

    // field widths fixed by the item formats
    localparam int TIME_W     = 32;
    localparam int TIME_FRAC  = 16;
    localparam int KIN_W      = 48;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // shared arithmetic units
    localparam int OP_W      = 64;
    localparam int LIMB_W    = 32;
    localparam int DIVISOR_W = 32;

    localparam int MAX_KNOTS_DEF = 256;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KNOT_COUNT = 1'd1;

    typedef logic signed [KIN_W-1:0] kin_t;
    typedef logic [TIME_W-1:0]       time_t;
    typedef logic [OP_W-1:0]         op_t;

endpackage

// ===== src/cjt_if.sv =====
interface cjt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [cjt_pkg::IDX_W-1:0]   knot_index;
    cjt_pkg::time_t              query_time;
    cjt_pkg::kin_t               in_position;
    cjt_pkg::kin_t               in_velocity;
    cjt_pkg::kin_t               in_acceleration;
    cjt_pkg::kin_t               in_jerk;

    modport source (
        output valid, mode, knot_index, query_time,
        output in_position, in_velocity, in_acceleration, in_jerk,
        input  ready
    );
    modport sink (
        input  valid, mode, knot_index, query_time,
        input  in_position, in_velocity, in_acceleration, in_jerk,
        output ready
    );
endinterface

interface cjt_out_if;
    logic          valid;
    logic          ready;
    cjt_pkg::kin_t out_position;
    cjt_pkg::kin_t out_velocity;
    cjt_pkg::kin_t out_acceleration;
    cjt_pkg::kin_t out_jerk;
    logic          status;

    modport source (
        output valid, out_position, out_velocity, out_acceleration, out_jerk, status,
        input  ready
    );
    modport sink (
        input  valid, out_position, out_velocity, out_acceleration, out_jerk, status,
        output ready
    );
endinterface

// ===== src/cjt_mul.sv =====
module cjt_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cjt_pkg::OP_W-1:0]     a,
    input  logic [cjt_pkg::OP_W-1:0]     b,
    output logic [2*cjt_pkg::OP_W-1:0]   p,
    output logic                         done
);

    localparam int OW = cjt_pkg::OP_W;
    localparam int LW = cjt_pkg::LIMB_W;
    localparam int PW = 2 * OW;
    localparam logic [2:0] CNT_FLUSH = 3'd4;

    logic [OW-1:0]   a_reg, a_next;
    logic [OW-1:0]   b_reg, b_next;
    logic [PW-1:0]   acc_reg, acc_next;
    logic [2*LW-1:0] prod_reg, prod_next;
    logic [1:0]      pos_reg, pos_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            pv_reg, pv_next;
    logic            done_reg, done_next;

    logic [LW-1:0]   a_limb;
    logic [LW-1:0]   b_limb;
    logic [PW-1:0]   prod_shifted;

    assign a_limb = cnt_reg[1] ? a_reg[OW-1:LW] : a_reg[LW-1:0];
    assign b_limb = cnt_reg[0] ? b_reg[OW-1:LW] : b_reg[LW-1:0];

    // partial product weight is 2^(32*(i+j))
    always_comb
    begin
        case (pos_reg)
            2'd0:    prod_shifted = PW'(prod_reg);
            2'd1:    prod_shifted = PW'(prod_reg) << LW;
            2'd2:    prod_shifted = PW'(prod_reg) << (2 * LW);
            default: prod_shifted = '0;
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        pv_next   = 1'b0;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pv_reg)
            begin
                acc_next = acc_reg + prod_shifted;
            end
            if (cnt_reg != CNT_FLUSH)
            begin
                prod_next = (2*LW)'(a_limb) * (2*LW)'(b_limb);
                pos_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                pv_next   = 1'b1;
                cnt_next  = cnt_reg + 3'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            pv_reg   <= pv_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        pos_reg  <= pos_next;
    end

    assign p    = acc_reg;
    assign done = done_reg;

endmodule

// ===== src/cjt_div.sv =====
module cjt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cjt_pkg::OP_W-1:0]      dividend,
    input  logic [cjt_pkg::DIVISOR_W-1:0] divisor,
    output logic [cjt_pkg::OP_W-1:0]      quotient,
    output logic [cjt_pkg::DIVISOR_W-1:0] remainder,
    output logic                          done
);

    localparam int OW = cjt_pkg::OP_W;
    localparam int DW = cjt_pkg::DIVISOR_W;
    localparam int CW = $clog2(OW);
    localparam logic [CW-1:0] CNT_LAST = CW'(OW - 1);

    logic [OW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign trial = {rem_reg, quo_reg[OW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[OW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== src/constant_jerk_trajectory_eval_top.sv =====
// constant-jerk trajectory evaluator
// item channel (valid/ready): mode load writes one knot (position, velocity,
// acceleration, jerk) into the table at knot_index and gives no
// result; mode query samples the trajectory at query_time and gives exactly
// one transaction on the result channel.
// config port: cfg_we with cfg_index 0 writes time_step, 1 writes knot_count;
// write only while the block is idle.
// a query inside the horizon runs the shared 64-step restoring divider once
// for time/step, then nine 64x64 products (eight when the jerk term already
// clips) pass four times each through the shared 32x32 multiplier, the
// divide by six being a reciprocal product. a query at the horizon uses no
// products, and one beyond it does not read the knot table.
// item ready is high only while the sequencer is idle, so a query can be taken
// in the same cycle the previous result appears; loads can go back to back.
// the result sits in an output register; a new item is taken while it waits,
// and a finished query holds in its last state until the register is free.
// reset sets time_step to 1.0 s and knot_count to 2 and drops any pending
// result; knot table contents are not cleared.
module constant_jerk_trajectory_eval_top #(
    parameter int MAX_KNOTS = cjt_pkg::MAX_KNOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cjt_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [cjt_pkg::CFG_DATA_W-1:0] cfg_data,
    cjt_in_if.sink                         item,
    cjt_out_if.source                      result
);

    localparam int AW    = $clog2(MAX_KNOTS);
    localparam int CW    = $clog2(MAX_KNOTS + 1);
    localparam int KW    = cjt_pkg::KIN_W;
    localparam int TW    = cjt_pkg::TIME_W;
    localparam int FRAC  = cjt_pkg::TIME_FRAC;
    localparam int OW    = cjt_pkg::OP_W;
    localparam int PW    = 2 * OW;
    localparam int DW    = cjt_pkg::DIVISOR_W;
    localparam int ACC_W = 64;

    localparam logic [OW-1:0] TERM_LIM  = OW'(64'h1000_0000_0000_0000);
    // floor(x/6) is the product with ceil(2^66/6) shifted down by 66
    localparam logic [OW-1:0] RECIP_SIX = OW'(64'hAAAA_AAAA_AAAA_AAAB);
    localparam logic signed [ACC_W-1:0] KIN_MAX = {{(ACC_W-KW+1){1'b0}}, {(KW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] KIN_MIN = {{(ACC_W-KW+1){1'b1}}, {(KW-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_UNPK  = 4'd4;
    localparam logic [3:0] S_T2    = 4'd5;
    localparam logic [3:0] S_T3    = 4'd6;
    localparam logic [3:0] S_TS    = 4'd7;
    localparam logic [3:0] S_TM    = 4'd8;
    localparam logic [3:0] S_TD    = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    localparam logic [1:0] RES_BEYOND = 2'd0;
    localparam logic [1:0] RES_KNOT   = 2'd1;
    localparam logic [1:0] RES_EVAL   = 2'd2;

    localparam logic [2:0] TERM_V_TAU  = 3'd0;
    localparam logic [2:0] TERM_A_TAU2 = 3'd1;
    localparam logic [2:0] TERM_J_TAU3 = 3'd2;
    localparam logic [2:0] TERM_A_TAU  = 3'd3;
    localparam logic [2:0] TERM_J_TAU2 = 3'd4;
    localparam logic [2:0] TERM_J_TAU  = 3'd5;

    localparam logic [1:0] DST_S = 2'd0;
    localparam logic [1:0] DST_V = 2'd1;
    localparam logic [1:0] DST_A = 2'd2;

    localparam logic [1:0] Y_TAU  = 2'd0;
    localparam logic [1:0] Y_TAU2 = 2'd1;
    localparam logic [1:0] Y_TAU3 = 2'd2;

    function automatic cjt_pkg::kin_t sat_kin(input logic signed [ACC_W-1:0] x);
        cjt_pkg::kin_t r;
        if (x > KIN_MAX)
        begin
            r = KIN_MAX[KW-1:0];
        end
        else if (x < KIN_MIN)
        begin
            r = KIN_MIN[KW-1:0];
        end
        else
        begin
            r = x[KW-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [TW-1:0]             time_step_reg;
    logic [cjt_pkg::CNT_W-1:0] knot_count_reg;

    // sequencer and datapath registers
    logic [3:0]                state_reg, state_next;
    logic [1:0]                kind_reg, kind_next;
    logic [2:0]                term_idx_reg, term_idx_next;
    logic [TW-1:0]             tau_reg, tau_next;
    logic [2*TW-FRAC-1:0]      tau2_reg, tau2_next;
    logic [OW-1:0]             tau3_reg, tau3_next;
    logic [AW-1:0]             addr_reg, addr_next;
    cjt_pkg::kin_t             pos_reg, pos_next;
    cjt_pkg::kin_t             vel_reg, vel_next;
    cjt_pkg::kin_t             acc_reg, acc_next;
    cjt_pkg::kin_t             jerk_reg, jerk_next;
    logic signed [ACC_W-1:0]   sum_s_reg, sum_s_next;
    logic signed [ACC_W-1:0]   sum_v_reg, sum_v_next;
    logic signed [ACC_W-1:0]   sum_a_reg, sum_a_next;
    logic signed [ACC_W-1:0]   term_reg, term_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    cjt_pkg::kin_t             out_pos_reg, out_pos_next;
    cjt_pkg::kin_t             out_vel_reg, out_vel_next;
    cjt_pkg::kin_t             out_acc_reg, out_acc_next;
    cjt_pkg::kin_t             out_jerk_reg, out_jerk_next;
    logic                      out_status_reg, out_status_next;

    // knot table
    logic [4*KW-1:0]           knot_mem [MAX_KNOTS];
    logic [4*KW-1:0]           rd_data_reg;
    cjt_pkg::kin_t             rd_pos;
    cjt_pkg::kin_t             rd_vel;
    cjt_pkg::kin_t             rd_acc;
    cjt_pkg::kin_t             rd_jerk;
    logic                      knot_we;
    logic [AW-1:0]             wr_addr;

    // shared units
    logic                      mul_start;
    logic [OW-1:0]             mul_a;
    logic [OW-1:0]             mul_b;
    logic [PW-1:0]             mul_p;
    logic                      mul_done;
    logic                      div_start;
    logic [OW-1:0]             div_dividend;
    logic [DW-1:0]             div_divisor;
    logic [OW-1:0]             div_quo;
    logic [DW-1:0]             div_rem;
    logic                      div_done;

    // misc combinational
    logic                      in_accept;
    logic [CW-1:0]             cnt_eff;
    logic [CW-1:0]             last_idx;
    logic [DW-1:0]             step_eff;
    cjt_pkg::kin_t             fac;
    logic                      fac_neg;
    logic [KW-1:0]             fac_mag;
    logic [1:0]                t_ysel;
    logic [OW-1:0]             t_y;
    logic                      t_sh17;
    logic                      t_div6;
    logic [1:0]                t_dst;
    logic                      t_ovf;
    logic [OW-1:0]             t_lo;
    logic [OW-1:0]             clip_src;
    logic [OW-1:0]             clip_mag;
    logic                      out_free;

    assign in_accept  = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (knot_count_reg < cjt_pkg::CNT_W'(2))
        begin
            cnt_eff = CW'(2);
        end
        else if (32'(knot_count_reg) > MAX_KNOTS)
        begin
            cnt_eff = CW'(MAX_KNOTS);
        end
        else
        begin
            cnt_eff = CW'(knot_count_reg);
        end
    end

    assign last_idx = cnt_eff - CW'(1);
    assign step_eff = (time_step_reg == '0) ? DW'(1) : DW'(time_step_reg);

    assign rd_pos  = rd_data_reg[4*KW-1:3*KW];
    assign rd_vel  = rd_data_reg[3*KW-1:2*KW];
    assign rd_acc  = rd_data_reg[2*KW-1:KW];
    assign rd_jerk = rd_data_reg[KW-1:0];

    assign knot_we = in_accept && (item.mode == cjt_pkg::MODE_LOAD)
                     && (32'(item.knot_index) < MAX_KNOTS);
    assign wr_addr = AW'(item.knot_index);

    // term table: factor, time power, scaling and destination sum
    always_comb
    begin
        case (term_idx_reg)
            TERM_V_TAU:
            begin
                fac = vel_reg;  t_ysel = Y_TAU;  t_sh17 = 1'b0; t_div6 = 1'b0; t_dst = DST_S;
            end
            TERM_A_TAU2:
            begin
                fac = acc_reg;  t_ysel = Y_TAU2; t_sh17 = 1'b1; t_div6 = 1'b0; t_dst = DST_S;
            end
            TERM_J_TAU3:
            begin
                fac = jerk_reg; t_ysel = Y_TAU3; t_sh17 = 1'b0; t_div6 = 1'b1; t_dst = DST_S;
            end
            TERM_A_TAU:
            begin
                fac = acc_reg;  t_ysel = Y_TAU;  t_sh17 = 1'b0; t_div6 = 1'b0; t_dst = DST_V;
            end
            TERM_J_TAU2:
            begin
                fac = jerk_reg; t_ysel = Y_TAU2; t_sh17 = 1'b1; t_div6 = 1'b0; t_dst = DST_V;
            end
            default:
            begin
                fac = jerk_reg; t_ysel = Y_TAU;  t_sh17 = 1'b0; t_div6 = 1'b0; t_dst = DST_A;
            end
        endcase
    end

    always_comb
    begin
        case (t_ysel)
            Y_TAU:   t_y = OW'(tau_reg);
            Y_TAU2:  t_y = OW'(tau2_reg);
            Y_TAU3:  t_y = tau3_reg;
            default: t_y = '0;
        endcase
    end

    assign fac_neg = fac[KW-1];
    assign fac_mag = fac_neg ? (~fac + KW'(1)) : fac;

    // product scaled back to Q24.24, anything past 64 bits saturates the term
    always_comb
    begin
        if (t_sh17)
        begin
            t_ovf = |mul_p[PW-1:OW+FRAC+1];
            t_lo  = mul_p[OW+FRAC:FRAC+1];
        end
        else
        begin
            t_ovf = |mul_p[PW-1:OW+FRAC];
            t_lo  = mul_p[OW+FRAC-1:FRAC];
        end
    end

    assign clip_src = (state_reg == S_TD) ? OW'(mul_p[PW-1:OW+2]) : t_lo;
    assign clip_mag = (t_ovf && (state_reg != S_TD)) ? TERM_LIM
                    : ((clip_src > TERM_LIM) ? TERM_LIM : clip_src);

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        term_idx_next   = term_idx_reg;
        tau_next        = tau_reg;
        tau2_next       = tau2_reg;
        tau3_next       = tau3_reg;
        addr_next       = addr_reg;
        pos_next        = pos_reg;
        vel_next        = vel_reg;
        acc_next        = acc_reg;
        jerk_next       = jerk_reg;
        sum_s_next      = sum_s_reg;
        sum_v_next      = sum_v_reg;
        sum_a_next      = sum_a_reg;
        term_next       = term_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_vel_next    = out_vel_reg;
        out_acc_next    = out_acc_reg;
        out_jerk_next   = out_jerk_reg;
        out_status_next = out_status_reg;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (item.mode == cjt_pkg::MODE_QUERY))
                begin
                    div_start    = 1'b1;
                    div_dividend = OW'(item.query_time);
                    div_divisor  = step_eff;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                // quotient against the last knot decides interval, horizon or beyond
                tau_next = TW'(div_rem);
                if (div_quo < OW'(last_idx))
                begin
                    addr_next  = div_quo[AW-1:0];
                    kind_next  = RES_EVAL;
                    state_next = S_RD;
                end
                else if ((div_quo == OW'(last_idx)) && (div_rem == '0))
                begin
                    addr_next  = AW'(last_idx);
                    kind_next  = RES_KNOT;
                    state_next = S_RD;
                end
                else
                begin
                    kind_next  = RES_BEYOND;
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_UNPK;
            end
            S_UNPK:
            begin
                if (kind_reg == RES_KNOT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = rd_pos;
                    vel_next   = rd_vel;
                    acc_next   = rd_acc;
                    jerk_next  = rd_jerk;
                    sum_s_next = ACC_W'(rd_pos);
                    sum_v_next = ACC_W'(rd_vel);
                    sum_a_next = ACC_W'(rd_acc);
                    mul_start  = 1'b1;
                    mul_a      = OW'(tau_reg);
                    mul_b      = OW'(tau_reg);
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                if (mul_done)
                begin
                    tau2_next  = mul_p[2*TW-1:FRAC];
                    mul_start  = 1'b1;
                    mul_a      = OW'(mul_p[2*TW-1:FRAC]);
                    mul_b      = OW'(tau_reg);
                    state_next = S_T3;
                end
            end
            S_T3:
            begin
                if (mul_done)
                begin
                    tau3_next     = mul_p[OW+FRAC-1:FRAC];
                    term_idx_next = TERM_V_TAU;
                    state_next    = S_TS;
                end
            end
            S_TS:
            begin
                mul_start  = 1'b1;
                mul_a      = OW'(fac_mag);
                mul_b      = t_y;
                state_next = S_TM;
            end
            S_TM:
            begin
                if (mul_done)
                begin
                    if (t_div6 && !t_ovf)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = t_lo;
                        mul_b      = RECIP_SIX;
                        state_next = S_TD;
                    end
                    else
                    begin
                        term_next  = fac_neg ? -clip_mag : clip_mag;
                        state_next = S_ACC;
                    end
                end
            end
            S_TD:
            begin
                if (mul_done)
                begin
                    term_next  = fac_neg ? -clip_mag : clip_mag;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                case (t_dst)
                    DST_S:   sum_s_next = sum_s_reg + term_reg;
                    DST_V:   sum_v_next = sum_v_reg + term_reg;
                    default: sum_a_next = sum_a_reg + term_reg;
                endcase
                if (term_idx_reg == TERM_J_TAU)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    term_idx_next = term_idx_reg + 3'd1;
                    state_next    = S_TS;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (kind_reg)
                        RES_KNOT:
                        begin
                            out_pos_next    = rd_pos;
                            out_vel_next    = rd_vel;
                            out_acc_next    = rd_acc;
                            out_jerk_next   = rd_jerk;
                            out_status_next = 1'b0;
                        end
                        RES_EVAL:
                        begin
                            out_pos_next    = sat_kin(sum_s_reg);
                            out_vel_next    = sat_kin(sum_v_reg);
                            out_acc_next    = sat_kin(sum_a_reg);
                            out_jerk_next   = jerk_reg;
                            out_status_next = 1'b0;
                        end
                        default:
                        begin
                            out_pos_next    = '0;
                            out_vel_next    = '0;
                            out_acc_next    = '0;
                            out_jerk_next   = '0;
                            out_status_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TW'(65536);
            knot_count_reg <= cjt_pkg::CNT_W'(2);
            state_reg      <= S_IDLE;
            kind_reg       <= RES_BEYOND;
            term_idx_reg   <= TERM_V_TAU;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == cjt_pkg::REG_TIME_STEP))
            begin
                time_step_reg <= cfg_data[TW-1:0];
            end
            if (cfg_we && (cfg_index == cjt_pkg::REG_KNOT_COUNT))
            begin
                knot_count_reg <= cfg_data[cjt_pkg::CNT_W-1:0];
            end
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            term_idx_reg  <= term_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tau_reg        <= tau_next;
        tau2_reg       <= tau2_next;
        tau3_reg       <= tau3_next;
        addr_reg       <= addr_next;
        pos_reg        <= pos_next;
        vel_reg        <= vel_next;
        acc_reg        <= acc_next;
        jerk_reg       <= jerk_next;
        sum_s_reg      <= sum_s_next;
        sum_v_reg      <= sum_v_next;
        sum_a_reg      <= sum_a_next;
        term_reg       <= term_next;
        out_pos_reg    <= out_pos_next;
        out_vel_reg    <= out_vel_next;
        out_acc_reg    <= out_acc_next;
        out_jerk_reg   <= out_jerk_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (knot_we)
        begin
            knot_mem[wr_addr] <= {item.in_position, item.in_velocity,
                                  item.in_acceleration, item.in_jerk};
        end
        rd_data_reg <= knot_mem[addr_reg];
    end

    cjt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    cjt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign result.valid            = out_valid_reg;
    assign result.out_position     = out_pos_reg;
    assign result.out_velocity     = out_vel_reg;
    assign result.out_acceleration = out_acc_reg;
    assign result.out_jerk         = out_jerk_reg;
    assign result.status           = out_status_reg;

endmodule
